### rtl/euclidean_distance_macros.svh
// Assertion macros for the euclidean distance block.
`ifndef EUCLIDEAN_DISTANCE_MACROS_SVH
`define EUCLIDEAN_DISTANCE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ED_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("euclidean_distance: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define ED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("euclidean_distance: next-cycle check failed");
`else
`define ED_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/ed_pkg.sv
// Shared constants and types for the euclidean distance block.
`default_nettype none
package ed_pkg;

    // element width of each vector field
    localparam int ELEM_WIDTH  = 16;
    // accumulator and result widths
    localparam int SUM_W       = 48;
    localparam int DIST_W      = 24;
    // magnitudes at or above 2^DIST_W saturate, so the multiplier is at most DIST_W wide
    localparam int SQ_IN_W     = (ELEM_WIDTH > DIST_W) ? DIST_W : ELEM_WIDTH;
    localparam int SQ_W        = 2 * SQ_IN_W;
    // stream word widths
    localparam int IN_TDATA_W  = ((2 * ELEM_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;
    // queue between accumulator and square root unit
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = 1;

    // one finished vector: raw Q32.16 sum and its saturation flag
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             sat;
    } t_vec_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
        logic idle;
    } t_back_status;

endpackage
`default_nettype wire

### rtl/ed_front.sv
// Front end: difference, square and saturating accumulation per element pair.
`default_nettype none
module ed_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [ed_pkg::ELEM_WIDTH-1:0] i_elem_a,
    input  wire logic signed [ed_pkg::ELEM_WIDTH-1:0] i_elem_b,
    input  wire logic                               i_last,
    output logic                                    o_push,
    output ed_pkg::t_vec_result                     o_push_data,
    input  wire ed_pkg::t_queue_status              i_q_status
);

    localparam int EW = ed_pkg::ELEM_WIDTH;

    logic                           r_s1_valid;
    logic                           r_s1_last;
    logic [EW-1:0]                  r_s1_mag;
    logic                           r_s2_valid;
    logic                           r_s2_last;
    logic                           r_s2_big;
    logic [ed_pkg::SQ_W-1:0]        r_s2_sq;
    logic [ed_pkg::SUM_W-1:0]       r_sum;
    logic                           r_sat;

    logic signed [EW:0]             w_diff;
    logic [EW:0]                    w_abs;
    logic                           w_big;
    logic [ed_pkg::SQ_IN_W-1:0]     w_sq_in;
    logic [ed_pkg::SUM_W:0]         w_add;
    logic                           w_ovf;
    logic [ed_pkg::SUM_W-1:0]       n_sum;
    logic                           n_sat;
    logic                           w_stall;

    // a finished vector waits in stage 2 while the queue is full
    assign w_stall = r_s2_valid & r_s2_last & i_q_status.full;
    assign o_ready = ~w_stall;

    // difference and magnitude, one bit wider than the elements
    assign w_diff = {i_elem_a[EW-1], i_elem_a} - {i_elem_b[EW-1], i_elem_b};
    assign w_abs  = w_diff[EW] ? (EW+1)'(-w_diff) : w_diff;

    // magnitudes past the multiplier width saturate outright
    generate
        if (EW > ed_pkg::DIST_W) begin : g_big
            assign w_big = |r_s1_mag[EW-1:ed_pkg::DIST_W];
        end else begin : g_nobig
            assign w_big = 1'b0;
        end
    endgenerate
    assign w_sq_in = r_s1_mag[ed_pkg::SQ_IN_W-1:0];

    // saturating add of the square into the running sum
    assign w_add = {1'b0, r_sum} + {1'b0, ed_pkg::SUM_W'(r_s2_sq)};
    assign w_ovf = r_s2_big | w_add[ed_pkg::SUM_W];
    assign n_sum = w_ovf ? '1 : w_add[ed_pkg::SUM_W-1:0];
    assign n_sat = r_sat | w_ovf;

    assign o_push           = r_s2_valid & r_s2_last & ~w_stall;
    assign o_push_data.sum  = n_sum;
    assign o_push_data.sat  = n_sat;

    // stage 1: magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s1_valid <= i_valid;
        end
        if (!w_stall) begin
            r_s1_last <= i_last;
            r_s1_mag  <= w_abs[EW-1:0];
        end
    end

    // stage 2: square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s2_valid <= r_s1_valid;
        end
        if (!w_stall) begin
            r_s2_last <= r_s1_last;
            r_s2_big  <= w_big;
            r_s2_sq   <= w_sq_in * w_sq_in;
        end
    end

    // stage 3: accumulate, clear after the last pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (r_s2_valid && !w_stall) begin
            if (r_s2_last) begin
                r_sum <= '0;
                r_sat <= 1'b0;
            end else begin
                r_sum <= n_sum;
                r_sat <= n_sat;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ed_queue.sv
// Short queue of finished vector sums between accumulator and square root unit.
`default_nettype none
module ed_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire ed_pkg::t_vec_result    i_push_data,
    input  wire logic                   i_pop,
    output ed_pkg::t_vec_result         o_pop_data,
    output ed_pkg::t_queue_status       o_status
);

    ed_pkg::t_vec_result        r_mem [ed_pkg::Q_DEPTH];
    logic [ed_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [ed_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [ed_pkg::Q_AW:0]      r_count;

    assign o_status.full  = (r_count == (ed_pkg::Q_AW+1)'(ed_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/ed_sqrt.sv
// Back end: bit-serial floored square root of a vector sum, with output register.
`default_nettype none
module ed_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ed_pkg::t_queue_status      i_q_status,
    input  wire ed_pkg::t_vec_result        i_data,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [ed_pkg::DIST_W-1:0]       o_distance,
    output logic                            o_overflow,
    output ed_pkg::t_back_status            o_status
);

    localparam int SW = ed_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state         r_state;
    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_root;
    logic [SW-1:0]  r_bit;
    logic           r_ovf;

    logic [SW-1:0]  w_trial;
    logic           w_take;

    assign w_trial = r_root + r_bit;
    assign w_take  = (r_rem >= w_trial);

    assign o_pop           = (r_state == S_IDLE) & ~i_q_status.empty;
    assign o_valid         = (r_state == S_OUT);
    assign o_distance      = r_root[ed_pkg::DIST_W-1:0];
    assign o_overflow      = r_ovf;
    assign o_status.busy   = (r_state == S_CALC);
    assign o_status.idle   = (r_state == S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (r_bit[0]) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // one result bit per cycle, trial subtract against root plus bit
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rem  <= i_data.sum;
            r_ovf  <= i_data.sat;
            r_root <= '0;
            r_bit  <= SW'(1) << (SW - 2);
        end else if (r_state == S_CALC) begin
            if (w_take) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule
`default_nettype wire

### rtl/euclidean_distance.sv
// Euclidean distance over streamed Q8.8 element pairs: top level.
//
// Input stream: each word carries one element of vector A and the matching
// element of vector B (signed Q8.8); tlast marks the final pair of a vector.
// Output stream: one word per vector, the floored square root of the summed
// squared differences as unsigned Q16.8, with tuser set if the sum saturated.
// Throughput: one pair per cycle while input ready is high. The accumulator
// is a three-stage pipeline (difference, multiply, add) that feeds a
// two-entry queue of finished sums. The square root unit produces one result
// bit per cycle over the 24 bits of a result, after a load step and before
// an output step, and takes no new vector until its result word is taken;
// vectors that end faster back up into the queue and then hold the input
// ready low.
// Reset clears the running sum, the queue and the sequencer. When the
// receiver stalls, the result word holds in its register and further sums
// wait in the queue.
`default_nettype none
`include "euclidean_distance_macros.svh"
module euclidean_distance (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [ELEM_WIDTH-1:0] elem_a, [2*ELEM_WIDTH-1:ELEM_WIDTH] elem_b, rest zero
    input  wire logic [ed_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  wire logic                               i_s_axis_tlast,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [23:0] distance
    output logic [ed_pkg::OUT_TDATA_W-1:0]          o_m_axis_tdata,
    // [0] overflow
    output logic                                    o_m_axis_tuser
);

    localparam int EW = ed_pkg::ELEM_WIDTH;

    logic                           w_push;
    ed_pkg::t_vec_result            w_push_data;
    logic                           w_pop;
    ed_pkg::t_vec_result            w_pop_data;
    ed_pkg::t_queue_status          w_q_status;
    ed_pkg::t_back_status           w_back_status;
    logic [ed_pkg::DIST_W-1:0]      w_distance;

    // accumulator
    ed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_elem_a    (i_s_axis_tdata[EW-1:0]),
        .i_elem_b    (i_s_axis_tdata[2*EW-1:EW]),
        .i_last      (i_s_axis_tlast),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_q_status  (w_q_status)
    );

    // queue of finished sums
    ed_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_q_status)
    );

    // square root and output register
    ed_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_data      (w_pop_data),
        .o_pop       (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_distance  (w_distance),
        .o_overflow  (o_m_axis_tuser),
        .o_status    (w_back_status)
    );

    assign o_m_axis_tdata = ed_pkg::OUT_TDATA_W'(w_distance);

    // checks across front, queue and back
    `ED_ASSERT_IMP(a_push_not_full, i_clk, i_rst_n, w_push, !w_q_status.full)
    `ED_ASSERT_IMP(a_stall_means_full, i_clk, i_rst_n, !o_s_axis_tready, w_q_status.full)
    `ED_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_status.empty && w_back_status.idle)
    `ED_ASSERT_NEXT(a_pop_starts_calc, i_clk, i_rst_n, w_pop, w_back_status.busy && !o_m_axis_tvalid)

endmodule
`default_nettype wire
